FILE: rtl/dcfcc_pkg.sv
// shared types and constants for the contact force block
package dcfcc_pkg;

    localparam int FW = 32;
    localparam int MW = 16;
    localparam int STEPS = 32;

    typedef struct packed {
        logic signed [FW-1:0] tangential_force_x;
        logic signed [FW-1:0] tangential_force_y;
        logic signed [FW-1:0] prior_normal_force;
        logic signed [FW-1:0] indentation;
        logic [FW-1:0]        normal_stiffness;
        logic                 bond_broken;
        logic [MW-1:0]        friction_coefficient;
    } t_item_in;

    typedef struct packed {
        logic signed [FW-1:0] result_force_x;
        logic signed [FW-1:0] result_force_y;
        logic signed [FW-1:0] result_normal_force;
    } t_item_out;

    typedef struct packed {
        logic signed [FW-1:0] fx;
        logic signed [FW-1:0] fy;
        logic signed [FW-1:0] fn;
        logic                 cap;
        logic [2*FW-1:0]      dx;
        logic [2*FW-1:0]      dy;
    } t_side;

    typedef struct packed {
        logic [FW+2:0]   rem;
        logic [FW-1:0]   root;
        logic [2*FW-1:0] rad;
    } t_sqrt;

    typedef struct packed {
        logic [FW-1:0] rem;
        logic [FW-1:0] lo;
        logic [FW-1:0] quo;
    } t_lane;

endpackage

FILE: rtl/dcfcc_front.sv
// normal force update, friction limit, squares, cap test and scaled tangential magnitudes
module dcfcc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  dcfcc_pkg::t_item_in i_item,
    output logic              o_vld,
    output dcfcc_pkg::t_side  o_side,
    output logic [63:0]       o_sum
);

    logic                r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld;
    dcfcc_pkg::t_item_in r_a_in, r_b_in, r_c_in, r_d_in;
    logic signed [64:0]  r_a_prod;
    logic                r_a_upd;
    logic [31:0]         r_a_ax, r_a_ay, r_b_ax, r_b_ay, r_c_ax, r_c_ay, r_d_ax, r_d_ay;
    logic signed [31:0]  r_b_fn, r_c_fn, r_d_fn;
    logic [63:0]         r_b_sqx, r_b_sqy, r_c_sum, r_d_sum, r_e_sum;
    logic [34:0]         r_c_lim;
    logic [31:0]         r_d_lim;
    logic                r_d_limok;
    logic [63:0]         r_d_lim2;
    dcfcc_pkg::t_side    r_e_side;

    logic signed [64:0]  shifted;
    logic signed [31:0]  n_fn;
    logic [46:0]         lim_prod;

    assign shifted = r_a_prod >>> 16;

    always_comb begin
        if (shifted[64:31] == '0 || shifted[64:31] == '1) begin
            n_fn = shifted[31:0];
        end else if (shifted[64]) begin
            n_fn = 32'sh8000_0000;
        end else begin
            n_fn = 32'sh7fff_ffff;
        end
    end

    assign lim_prod = (r_b_fn > 0) ? 47'(r_b_in.friction_coefficient * r_b_fn[30:0]) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_in   <= i_item;
        r_a_prod <= $signed({1'b0, i_item.normal_stiffness}) * i_item.indentation;
        r_a_upd  <= (i_item.indentation > 0) || !i_item.bond_broken;
        r_a_ax   <= i_item.tangential_force_x[31] ? 32'(-i_item.tangential_force_x)
                                                  : i_item.tangential_force_x;
        r_a_ay   <= i_item.tangential_force_y[31] ? 32'(-i_item.tangential_force_y)
                                                  : i_item.tangential_force_y;

        r_b_in  <= r_a_in;
        r_b_fn  <= r_a_upd ? n_fn : r_a_in.prior_normal_force;
        r_b_sqx <= r_a_ax * r_a_ax;
        r_b_sqy <= r_a_ay * r_a_ay;
        r_b_ax  <= r_a_ax;
        r_b_ay  <= r_a_ay;

        r_c_in  <= r_b_in;
        r_c_fn  <= r_b_fn;
        r_c_lim <= lim_prod[46:12];
        r_c_sum <= r_b_sqx + r_b_sqy;
        r_c_ax  <= r_b_ax;
        r_c_ay  <= r_b_ay;

        r_d_in    <= r_c_in;
        r_d_fn    <= r_c_fn;
        r_d_lim   <= r_c_lim[31:0];
        r_d_limok <= (r_c_lim[34:32] == '0);
        r_d_lim2  <= r_c_lim[31:0] * r_c_lim[31:0];
        r_d_sum   <= r_c_sum;
        r_d_ax    <= r_c_ax;
        r_d_ay    <= r_c_ay;

        r_e_side.fx  <= r_d_in.tangential_force_x;
        r_e_side.fy  <= r_d_in.tangential_force_y;
        r_e_side.fn  <= r_d_fn;
        r_e_side.cap <= r_d_in.bond_broken && r_d_limok && (r_d_sum > r_d_lim2);
        r_e_side.dx  <= r_d_ax * r_d_lim;
        r_e_side.dy  <= r_d_ay * r_d_lim;
        r_e_sum      <= r_d_sum;
    end

    assign o_vld  = r_e_vld;
    assign o_side = r_e_side;
    assign o_sum  = r_e_sum;

endmodule

FILE: rtl/dcfcc_sqrt_cell.sv
// one root digit of the square root chain
module dcfcc_sqrt_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  dcfcc_pkg::t_side i_side,
    input  dcfcc_pkg::t_sqrt i_st,
    output logic             o_vld,
    output dcfcc_pkg::t_side o_side,
    output dcfcc_pkg::t_sqrt o_st
);

    logic             r_vld;
    dcfcc_pkg::t_side r_side;
    dcfcc_pkg::t_sqrt r_st;
    logic [34:0]      rem_sh;
    logic [34:0]      trial;
    logic             ge;

    assign rem_sh = {i_st.rem[32:0], i_st.rad[63:62]};
    assign trial  = {1'b0, i_st.root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side    <= i_side;
        r_st.rem  <= ge ? rem_sh - trial : rem_sh;
        r_st.root <= {i_st.root[30:0], ge};
        r_st.rad  <= {i_st.rad[61:0], 2'b00};
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_st   = r_st;

endmodule

FILE: rtl/dcfcc_div_cell.sv
// one quotient bit for both scaled components
module dcfcc_div_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  dcfcc_pkg::t_side i_side,
    input  logic [31:0]      i_div,
    input  dcfcc_pkg::t_lane i_x,
    input  dcfcc_pkg::t_lane i_y,
    output logic             o_vld,
    output dcfcc_pkg::t_side o_side,
    output logic [31:0]      o_div,
    output dcfcc_pkg::t_lane o_x,
    output dcfcc_pkg::t_lane o_y
);

    logic             r_vld;
    dcfcc_pkg::t_side r_side;
    logic [31:0]      r_div;
    dcfcc_pkg::t_lane r_x, r_y;
    logic [32:0]      sx, sy;
    logic             gx, gy;

    assign sx = {i_x.rem, i_x.lo[31]};
    assign sy = {i_y.rem, i_y.lo[31]};
    assign gx = sx >= {1'b0, i_div};
    assign gy = sy >= {1'b0, i_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side  <= i_side;
        r_div   <= i_div;
        r_x.rem <= gx ? 32'(sx - {1'b0, i_div}) : sx[31:0];
        r_x.lo  <= {i_x.lo[30:0], 1'b0};
        r_x.quo <= {i_x.quo[30:0], gx};
        r_y.rem <= gy ? 32'(sy - {1'b0, i_div}) : sy[31:0];
        r_y.lo  <= {i_y.lo[30:0], 1'b0};
        r_y.quo <= {i_y.quo[30:0], gy};
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_div  = r_div;
    assign o_x    = r_x;
    assign o_y    = r_y;

endmodule

FILE: rtl/dem_contact_force_coulomb_cap_top.sv
// contact force top: front stages, root chain, divider chain, output register
// throughput: one item per cycle, busy is never raised
// the front end has five stages, then one cell per root bit and per quotient bit
// synchronous active-low reset clears all valid flags, no result after reset
// results cannot be stalled by the receiver
module dem_contact_force_coulomb_cap_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  dcfcc_pkg::t_item_in  i_item,
    output logic                 o_done,
    output dcfcc_pkg::t_item_out o_result
);

    localparam int N = dcfcc_pkg::STEPS;

    logic             f_vld;
    dcfcc_pkg::t_side f_side;
    logic [63:0]      f_sum;

    logic             s_vld  [N+1];
    dcfcc_pkg::t_side s_side [N+1];
    dcfcc_pkg::t_sqrt s_st   [N+1];

    logic             d_vld  [N+1];
    dcfcc_pkg::t_side d_side [N+1];
    logic [31:0]      d_div  [N+1];
    dcfcc_pkg::t_lane d_x    [N+1];
    dcfcc_pkg::t_lane d_y    [N+1];

    logic                 r_done;
    dcfcc_pkg::t_item_out r_res;

    assign busy = 1'b0;

    dcfcc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start),
        .i_item  (i_item),
        .o_vld   (f_vld),
        .o_side  (f_side),
        .o_sum   (f_sum)
    );

    assign s_vld[0]      = f_vld;
    assign s_side[0]     = f_side;
    assign s_st[0].rem   = '0;
    assign s_st[0].root  = '0;
    assign s_st[0].rad   = f_sum;

    for (genvar g = 0; g < N; g++) begin : g_sqrt
        dcfcc_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (s_vld[g]),
            .i_side  (s_side[g]),
            .i_st    (s_st[g]),
            .o_vld   (s_vld[g+1]),
            .o_side  (s_side[g+1]),
            .o_st    (s_st[g+1])
        );
    end

    assign d_vld[0]   = s_vld[N];
    assign d_side[0]  = s_side[N];
    assign d_div[0]   = s_st[N].root;
    assign d_x[0].rem = s_side[N].dx[63:32];
    assign d_x[0].lo  = s_side[N].dx[31:0];
    assign d_x[0].quo = '0;
    assign d_y[0].rem = s_side[N].dy[63:32];
    assign d_y[0].lo  = s_side[N].dy[31:0];
    assign d_y[0].quo = '0;

    for (genvar g = 0; g < N; g++) begin : g_div
        dcfcc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (d_vld[g]),
            .i_side  (d_side[g]),
            .i_div   (d_div[g]),
            .i_x     (d_x[g]),
            .i_y     (d_y[g]),
            .o_vld   (d_vld[g+1]),
            .o_side  (d_side[g+1]),
            .o_div   (d_div[g+1]),
            .o_x     (d_x[g+1]),
            .o_y     (d_y[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= d_vld[N];
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.result_normal_force <= d_side[N].fn;
        if (d_side[N].cap) begin
            r_res.result_force_x <= d_side[N].fx[31] ? -$signed(d_x[N].quo)
                                                     : $signed(d_x[N].quo);
            r_res.result_force_y <= d_side[N].fy[31] ? -$signed(d_y[N].quo)
                                                     : $signed(d_y[N].quo);
        end else begin
            r_res.result_force_x <= d_side[N].fx;
            r_res.result_force_y <= d_side[N].fy;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
